@@ sv/ic3_pkg.sv @@
package ic3_pkg;

    localparam logic [2:0] REG_KERNEL_TOP    = 3'd0;
    localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd1;
    localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd4;

    localparam logic [23:0] KERNEL_TOP_RESET    = 24'h000000;
    localparam logic [23:0] KERNEL_MIDDLE_RESET = 24'h000100;
    localparam logic [23:0] KERNEL_BOTTOM_RESET = 24'h000000;
    localparam logic [11:0] WIDTH_RESET         = 12'd640;
    localparam logic [12:0] HEIGHT_RESET        = 13'd480;
    localparam logic [12:0] MAX_HEIGHT          = 13'd4096;

    localparam logic       CMD_PIXEL = 1'b0;
    localparam logic       CMD_FLUSH = 1'b1;

    localparam logic [7:0] CHAN_MAX  = 8'd255;

    typedef logic [31:0] pixel_t;
    typedef logic signed [19:0] acc_t;
    typedef logic signed [11:0] ksum_t;

endpackage

@@ sv/ic3_ram.sv @@
module ic3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/image_convolution_3x3.sv @@
// 3x3 convolution of red, green and blue with replicated borders, normalized by the
// kernel sum and clamped to 0..255; alpha is taken from the centre pixel. One word is
// worked at a time: a pixel word is written into a three-row line memory, then each
// result it releases reads its nine taps one by one from that single-read-port memory,
// takes in the last read, passes a setup state, runs a bit-serial divider over eight
// quotient bits and is handed over, where the output side can stall it (a pixel word
// releases zero, one or two results, a flush word at most one). A word that releases
// nothing leaves the block idle and ready for the next word.
// The last row of a frame comes out through flush words, one pixel each.
module image_convolution_3x3 #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [7:0]  alpha_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [7:0]  alpha_out,
    output logic        last_of_step,
    output logic        end_of_frame
);

    import ic3_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] BASE1 = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] BASE2 = AW'(2 * MAX_WIDTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [23:0] ktop_reg, kmid_reg, kbot_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;

    logic [2:0]    state_reg;
    logic [12:0]   row_reg;
    logic [1:0]    rm_reg;
    logic [XW-1:0] col_reg;
    logic [XW-1:0] fcol_reg;
    logic          fvalid_reg;
    logic [1:0]    lastm_reg;

    logic [1:0]    jr0_reg, jr1_reg, jr2_reg;
    logic [XW-1:0] jx_reg;
    logic          second_reg;
    logic          jlast_reg;
    logic          jeof_reg;

    logic [1:0] ky_reg, kx_reg, rky_reg, rkx_reg;
    logic       rv_reg;
    acc_t       acc_reg [3];
    ksum_t      ksum_reg;
    logic [7:0] alpha_reg;

    logic [18:0] rem_reg  [3];
    logic [7:0]  q_reg    [3];
    logic        zero_reg [3];
    logic        sat_reg  [3];
    logic [10:0] div_reg;
    logic [2:0]  bit_reg;

    logic       ov_reg;
    logic [7:0] ro_reg, go_reg, bo_reg, ao_reg;
    logic       lo_reg, eo_reg;

    logic [WW-1:0] w_eff;
    logic [12:0]   h_eff;
    logic [31:0]   w32;
    logic          cfg_wr;
    logic          in_fire;

    always_comb
    begin
        if (width_reg == 12'd0)
        begin
            w32 = 32'd1;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w32 = 32'(MAX_WIDTH);
        end
        else
        begin
            w32 = 32'(width_reg);
        end
        w_eff = w32[WW-1:0];
        if (height_reg == 13'd0)
        begin
            h_eff = 13'd1;
        end
        else if (height_reg > MAX_HEIGHT)
        begin
            h_eff = MAX_HEIGHT;
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[4:2])
            REG_KERNEL_TOP:    prdata = {8'd0, ktop_reg};
            REG_KERNEL_MIDDLE: prdata = {8'd0, kmid_reg};
            REG_KERNEL_BOTTOM: prdata = {8'd0, kbot_reg};
            REG_IMAGE_WIDTH:   prdata = {20'd0, width_reg};
            REG_IMAGE_HEIGHT:  prdata = {19'd0, height_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    function automatic logic [1:0] inc3(input logic [1:0] m);
        return (m == 2'd2) ? 2'd0 : m + 2'd1;
    endfunction

    function automatic logic [1:0] dec3(input logic [1:0] m);
        return (m == 2'd0) ? 2'd2 : m - 2'd1;
    endfunction

    function automatic logic [AW-1:0] base_of(input logic [1:0] m);
        case (m)
            2'd1:    return BASE1;
            2'd2:    return BASE2;
            default: return '0;
        endcase
    endfunction

    // pixel word placement
    logic [12:0]   p_row;
    logic [1:0]    p_rm;
    logic [XW-1:0] p_col;
    logic [31:0]   p_col1;
    logic          p_wrap;
    logic          p_j1, p_j2;
    logic [AW-1:0] waddr;
    logic          we;

    always_comb
    begin
        p_row = row_reg;
        p_rm  = rm_reg;
        p_col = col_reg;
        if (row_reg >= h_eff || 32'(col_reg) >= 32'(w_eff))
        begin
            p_row = '0;
            p_rm  = '0;
            p_col = '0;
        end
        p_col1 = 32'(p_col) + 32'd1;
        p_wrap = (p_col1 >= 32'(w_eff));
        p_j1   = (p_row != 13'd0) && (p_col != '0);
        p_j2   = (p_row != 13'd0) && (p_col1 == 32'(w_eff));
        waddr  = base_of(p_rm) + AW'(p_col);
        we     = in_fire && (command == CMD_PIXEL);
    end

    // read address for the current tap
    logic [1:0]    rd_rm;
    logic [XW-1:0] rd_col;
    logic [31:0]   jx1;
    logic [AW-1:0] raddr;
    logic          re;
    pixel_t        rdata;

    always_comb
    begin
        jx1 = 32'(jx_reg) + 32'd1;
        case (ky_reg)
            2'd0:    rd_rm = jr0_reg;
            2'd1:    rd_rm = jr1_reg;
            default: rd_rm = jr2_reg;
        endcase
        case (kx_reg)
            2'd0:    rd_col = (jx_reg == '0) ? jx_reg : jx_reg - XW'(1);
            2'd1:    rd_col = jx_reg;
            default: rd_col = (jx1 >= 32'(w_eff)) ? XW'(32'(w_eff) - 32'd1) : XW'(jx1);
        endcase
        raddr = base_of(rd_rm) + AW'(rd_col);
        re    = (state_reg == S_READ);
    end

    ic3_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_line (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata({alpha_in, blue_in, green_in, red_in}),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    // tap coefficient
    logic [23:0]       krow;
    logic signed [7:0] coef;

    always_comb
    begin
        case (rky_reg)
            2'd0:    krow = ktop_reg;
            2'd1:    krow = kmid_reg;
            default: krow = kbot_reg;
        endcase
        case (rkx_reg)
            2'd0:    coef = $signed(krow[7:0]);
            2'd1:    coef = $signed(krow[15:8]);
            default: coef = $signed(krow[23:16]);
        endcase
    end

    // divider setup and step
    logic [18:0]       s_abs  [3];
    logic              s_zero [3];
    logic              s_sat  [3];
    logic [10:0]       s_div;
    ksum_t             s_ks;
    logic [18:0]       trial;
    logic [7:0]        fin    [3];

    always_comb
    begin
        s_ks  = (ksum_reg == '0) ? ksum_t'(1) : ksum_reg;
        s_div = s_ks[11] ? 11'(-s_ks) : s_ks[10:0];
        for (int i = 0; i < 3; i++)
        begin
            s_abs[i]  = acc_reg[i][19] ? 19'(-acc_reg[i]) : acc_reg[i][18:0];
            s_zero[i] = (acc_reg[i] == '0) || (acc_reg[i][19] != s_ks[11]);
            s_sat[i]  = (s_abs[i] >= {s_div, 8'd0});
        end
        trial = 19'(div_reg) << bit_reg;
        // fold in the last quotient bit on the final step
        for (int i = 0; i < 3; i++)
        begin
            fin[i] = zero_reg[i] ? 8'd0 : (sat_reg[i] ? CHAN_MAX :
                     (q_reg[i] | {7'd0, rem_reg[i] >= trial}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ktop_reg   <= KERNEL_TOP_RESET;
            kmid_reg   <= KERNEL_MIDDLE_RESET;
            kbot_reg   <= KERNEL_BOTTOM_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            state_reg  <= S_IDLE;
            row_reg    <= '0;
            rm_reg     <= '0;
            col_reg    <= '0;
            fcol_reg   <= '0;
            fvalid_reg <= 1'b0;
            lastm_reg  <= '0;
            rv_reg     <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            rv_reg <= (state_reg == S_READ);
            if (cfg_wr)
            begin
                case (paddr[4:2])
                    REG_KERNEL_TOP:    ktop_reg <= pwdata[23:0];
                    REG_KERNEL_MIDDLE: kmid_reg <= pwdata[23:0];
                    REG_KERNEL_BOTTOM: kbot_reg <= pwdata[23:0];
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg  <= pwdata[11:0];
                        row_reg    <= '0;
                        rm_reg     <= '0;
                        col_reg    <= '0;
                        fcol_reg   <= '0;
                        fvalid_reg <= 1'b0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg <= pwdata[12:0];
                        row_reg    <= '0;
                        rm_reg     <= '0;
                        col_reg    <= '0;
                        fcol_reg   <= '0;
                        fvalid_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && command == CMD_PIXEL)
                    begin
                        fvalid_reg <= 1'b0;
                        if (p_wrap)
                        begin
                            col_reg <= '0;
                            if (32'(p_row) + 32'd1 >= 32'(h_eff))
                            begin
                                row_reg    <= '0;
                                rm_reg     <= '0;
                                fvalid_reg <= 1'b1;
                                fcol_reg   <= '0;
                                lastm_reg  <= p_rm;
                            end
                            else
                            begin
                                row_reg <= p_row + 13'd1;
                                rm_reg  <= inc3(p_rm);
                            end
                        end
                        else
                        begin
                            col_reg <= XW'(p_col1);
                            row_reg <= p_row;
                            rm_reg  <= p_rm;
                        end
                        if (p_j1 || p_j2)
                        begin
                            jr1_reg    <= dec3(p_rm);
                            jr0_reg    <= (p_row == 13'd1) ? dec3(p_rm) : inc3(p_rm);
                            jr2_reg    <= p_rm;
                            jx_reg     <= p_j1 ? p_col - XW'(1) : p_col;
                            second_reg <= p_j1 && p_j2;
                            jlast_reg  <= !(p_j1 && p_j2);
                            jeof_reg   <= 1'b0;
                            ky_reg     <= '0;
                            kx_reg     <= '0;
                            state_reg  <= S_READ;
                        end
                    end
                    else if (in_fire && fvalid_reg)
                    begin
                        if (32'(fcol_reg) >= 32'(w_eff))
                        begin
                            fvalid_reg <= 1'b0;
                        end
                        else
                        begin
                            jr1_reg    <= lastm_reg;
                            jr0_reg    <= (h_eff == 13'd1) ? lastm_reg : dec3(lastm_reg);
                            jr2_reg    <= lastm_reg;
                            jx_reg     <= fcol_reg;
                            second_reg <= 1'b0;
                            jlast_reg  <= 1'b1;
                            jeof_reg   <= (32'(fcol_reg) + 32'd1 >= 32'(w_eff));
                            fcol_reg   <= fcol_reg + XW'(1);
                            if (32'(fcol_reg) + 32'd1 >= 32'(w_eff))
                            begin
                                fvalid_reg <= 1'b0;
                            end
                            ky_reg     <= '0;
                            kx_reg     <= '0;
                            state_reg  <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    if (kx_reg == 2'd2)
                    begin
                        kx_reg <= '0;
                        ky_reg <= ky_reg + 2'd1;
                        if (ky_reg == 2'd2)
                        begin
                            state_reg <= S_LAST;
                        end
                    end
                    else
                    begin
                        kx_reg <= kx_reg + 2'd1;
                    end
                end
                S_LAST:  state_reg <= S_SETUP;
                S_SETUP: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (bit_reg == 3'd0)
                    begin
                        state_reg <= S_OUT;
                        ov_reg    <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        ov_reg <= 1'b0;
                        if (second_reg)
                        begin
                            second_reg <= 1'b0;
                            jlast_reg  <= 1'b1;
                            jx_reg     <= jx_reg + XW'(1);
                            ky_reg     <= '0;
                            kx_reg     <= '0;
                            state_reg  <= S_READ;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        rky_reg <= ky_reg;
        rkx_reg <= kx_reg;
        if (state_reg == S_READ && ky_reg == 2'd0 && kx_reg == 2'd0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= '0;
            end
            ksum_reg <= '0;
        end
        else if (rv_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= acc_reg[i]
                    + acc_t'(coef * $signed({1'b0, rdata[8*i +: 8]}));
            end
            ksum_reg <= ksum_reg + ksum_t'(coef);
            if (rky_reg == 2'd1 && rkx_reg == 2'd1)
            begin
                alpha_reg <= rdata[31:24];
            end
        end
        if (state_reg == S_SETUP)
        begin
            div_reg <= s_div;
            bit_reg <= 3'd7;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i]  <= s_abs[i];
                q_reg[i]    <= '0;
                zero_reg[i] <= s_zero[i];
                sat_reg[i]  <= s_sat[i];
            end
        end
        else if (state_reg == S_DIV)
        begin
            bit_reg <= bit_reg - 3'd1;
            for (int i = 0; i < 3; i++)
            begin
                if (rem_reg[i] >= trial)
                begin
                    rem_reg[i]       <= rem_reg[i] - trial;
                    q_reg[i][bit_reg] <= 1'b1;
                end
            end
        end
        if (state_reg == S_DIV && bit_reg == 3'd0)
        begin
            ro_reg <= fin[0];
            go_reg <= fin[1];
            bo_reg <= fin[2];
            ao_reg <= alpha_reg;
            lo_reg <= jlast_reg;
            eo_reg <= jeof_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign red_out      = ro_reg;
    assign green_out    = go_reg;
    assign blue_out     = bo_reg;
    assign alpha_out    = ao_reg;
    assign last_of_step = lo_reg;
    assign end_of_frame = eo_reg;

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT)
        else $error("result shown outside output state");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid && !rv_reg)
        else $error("input accepted during computation");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> last_of_step)
        else $error("frame end not on last result");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import ic3_pkg::*;

    localparam int MAXW = 2048;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } word_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       last;
        logic       eof;
    } pix_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = CMD_PIXEL;
    logic [7:0]  red_in = '0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic [7:0]  alpha_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        last_of_step;
    logic        end_of_frame;

    image_convolution_3x3 dut (.*);

    always #5 clk = ~clk;

    // shadow of the block's registers and frame state
    logic [23:0] k_top = KERNEL_TOP_RESET;
    logic [23:0] k_mid = KERNEL_MIDDLE_RESET;
    logic [23:0] k_bot = KERNEL_BOTTOM_RESET;
    logic [11:0] width_reg = WIDTH_RESET;
    logic [12:0] height_reg = HEIGHT_RESET;
    logic [31:0] line_mem [3][MAXW];
    int          row_pos = 0;
    int          col_pos = 0;
    int          flush_col = 0;
    bit          flush_pending = 0;

    word_t       pending [$];
    pix_res_t    expected_pix [$];
    bit          hold = 0;
    int          errors = 0;
    int          words_in = 0;
    int          results_seen = 0;
    int          flush_results = 0;
    int          frames_done = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          cyc = 0;
    int          rdy_mode = 0;

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAXW) return MAXW;
        return width_reg;
    endfunction

    function automatic int eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic pix_res_t conv_pixel(int y, int x);
        int rows [3];
        int cols [3];
        int acc [3];
        int ksum;
        int k;
        int q;
        int w;
        int h;
        logic [31:0] px;
        logic [23:0] krow [3];
        pix_res_t res;
        w = eff_width();
        h = eff_height();
        rows[0] = (y == 0) ? 0 : y - 1;
        rows[1] = y;
        rows[2] = (y + 1 >= h) ? h - 1 : y + 1;
        cols[0] = (x == 0) ? 0 : x - 1;
        cols[1] = x;
        cols[2] = (x + 1 >= w) ? w - 1 : x + 1;
        krow[0] = k_top;
        krow[1] = k_mid;
        krow[2] = k_bot;
        ksum = 0;
        acc[0] = 0;
        acc[1] = 0;
        acc[2] = 0;
        for (int ky = 0; ky < 3; ky++)
            for (int kx = 0; kx < 3; kx++)
            begin
                k = int'($signed(krow[ky][8*kx +: 8]));
                px = line_mem[rows[ky] % 3][cols[kx]];
                ksum += k;
                for (int ch = 0; ch < 3; ch++)
                    acc[ch] += k * int'(px[8*ch +: 8]);
            end
        if (ksum == 0) ksum = 1;
        for (int ch = 0; ch < 3; ch++)
        begin
            q = acc[ch] / ksum;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
            case (ch)
                0: res.r = q[7:0];
                1: res.g = q[7:0];
                default: res.b = q[7:0];
            endcase
        end
        px = line_mem[y % 3][x];
        res.a = px[31:24];
        res.last = 1'b0;
        res.eof = 1'b0;
        return res;
    endfunction

    task automatic predict_word(word_t wd);
        pix_res_t res [$];
        pix_res_t one;
        int w;
        int h;
        int r;
        int c;
        w = eff_width();
        h = eff_height();
        if (wd.cmd == CMD_FLUSH)
        begin
            if (!flush_pending) return;
            if (flush_col >= w)
            begin
                flush_pending = 0;
                return;
            end
            one = conv_pixel(h - 1, flush_col);
            one.last = 1'b1;
            flush_col++;
            if (flush_col >= w)
            begin
                flush_pending = 0;
                one.eof = 1'b1;
                frames_done++;
            end
            flush_results++;
            expected_pix.push_back(one);
            return;
        end
        r = row_pos;
        c = col_pos;
        flush_pending = 0;
        if (r >= h || c >= w)
        begin
            r = 0;
            c = 0;
        end
        line_mem[r % 3][c] = {wd.a, wd.b, wd.g, wd.r};
        if (r >= 1)
        begin
            if (c >= 1) res.push_back(conv_pixel(r - 1, c - 1));
            if (c + 1 == w) res.push_back(conv_pixel(r - 1, c));
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
                flush_pending = 1;
                flush_col = 0;
            end
        end
        row_pos = r;
        col_pos = c;
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        foreach (res[i]) expected_pix.push_back(res[i]);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (hold || pending.size() == 0 || !rst_n)
                in_valid <= 1'b0;
            else
            begin
                command <= pending[0].cmd;
                red_in <= pending[0].r;
                green_in <= pending[0].g;
                blue_in <= pending[0].b;
                alpha_in <= pending[0].a;
                in_valid <= 1'b1;
                void'(pending.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 300 == 0) rdy_mode <= $urandom_range(0, 3);
        case (rdy_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (cyc % 7 < 4);
        endcase
    end

    // monitor
    always @(posedge clk)
    begin
        pix_res_t e;
        if (in_valid && in_ready)
        begin
            words_in++;
            predict_word({command, red_in, green_in, blue_in, alpha_in});
        end
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (expected_pix.size() == 0)
            begin
                $error("unexpected output word");
                errors++;
            end
            else
            begin
                e = expected_pix.pop_front();
                if (red_out !== e.r)
                begin
                    $error("red_out expected %0d actual %0d", e.r, red_out);
                    errors++;
                end
                if (green_out !== e.g)
                begin
                    $error("green_out expected %0d actual %0d", e.g, green_out);
                    errors++;
                end
                if (blue_out !== e.b)
                begin
                    $error("blue_out expected %0d actual %0d", e.b, blue_out);
                    errors++;
                end
                if (alpha_out !== e.a)
                begin
                    $error("alpha_out expected %0d actual %0d", e.a, alpha_out);
                    errors++;
                end
                if (last_of_step !== e.last)
                begin
                    $error("last_of_step expected %0d actual %0d", e.last, last_of_step);
                    errors++;
                end
                if (end_of_frame !== e.eof)
                begin
                    $error("end_of_frame expected %0d actual %0d", e.eof, end_of_frame);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KERNEL_TOP: k_top = val[23:0];
            REG_KERNEL_MIDDLE: k_mid = val[23:0];
            REG_KERNEL_BOTTOM: k_bot = val[23:0];
            REG_IMAGE_WIDTH: width_reg = val[11:0];
            default: height_reg = val[12:0];
        endcase
        if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT)
        begin
            row_pos = 0;
            col_pos = 0;
            flush_col = 0;
            flush_pending = 0;
        end
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || in_valid || expected_pix.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_frame(logic [23:0] t, logic [23:0] m, logic [23:0] b,
                             logic [11:0] w, logic [12:0] h);
        wait_drained();
        reg_write(REG_KERNEL_TOP, {8'h0, t});
        reg_write(REG_KERNEL_MIDDLE, {8'h0, m});
        reg_write(REG_KERNEL_BOTTOM, {8'h0, b});
        reg_write(REG_IMAGE_WIDTH, {20'h0, w});
        reg_write(REG_IMAGE_HEIGHT, {19'h0, h});
    endtask

    function automatic logic [7:0] chan_val(int mode);
        case (mode)
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixels(int n, int mode);
        word_t wd;
        for (int i = 0; i < n; i++)
        begin
            wd.cmd = CMD_PIXEL;
            wd.r = chan_val(mode < 0 ? $urandom_range(0, 7) : mode);
            wd.g = chan_val(mode < 0 ? $urandom_range(0, 7) : mode);
            wd.b = chan_val(mode < 0 ? $urandom_range(0, 7) : mode);
            wd.a = chan_val(mode < 0 ? $urandom_range(0, 7) : mode);
            pending.push_back(wd);
        end
    endtask

    task automatic push_flushes(int n);
        word_t wd;
        for (int i = 0; i < n; i++)
        begin
            wd = word_t'($urandom);
            wd.cmd = CMD_FLUSH;
            pending.push_back(wd);
        end
    endtask

    function automatic logic [23:0] rand_krow(int mode);
        logic [23:0] v;
        case (mode)
            0: v = 24'($urandom);
            1: v = {5'h0, 3'($urandom), 5'h0, 3'($urandom), 5'h0, 3'($urandom)};
            default: v = {8'($urandom_range(0, 2) - 1), 8'($urandom_range(0, 2) - 1),
                          8'($urandom_range(0, 2) - 1)};
        endcase
        return v;
    endfunction

    initial
    begin
        int w;
        int h;
        int km;
        int big_done;
        big_done = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flush with nothing pending, then a frame at the reset kernel
        push_flushes(2);
        set_frame(24'h000000, 24'h000100, 24'h000000, 12'd3, 13'd3);
        push_pixels(3, 0);
        push_pixels(3, 1);
        push_pixels(3, 2);
        push_flushes(4);
        set_frame(24'h808080, 24'h808080, 24'h808080, 12'd3, 13'd2);
        push_pixels(6, 1);
        push_flushes(3);
        set_frame(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f, 12'd2, 13'd2);
        push_pixels(4, -1);
        push_flushes(2);
        // zero kernel sum, single row
        set_frame(24'h0100ff, 24'hff0001, 24'h000000, 12'd3, 13'd1);
        push_pixels(3, -1);
        push_flushes(3);
        // single column; flush interrupted by a new pixel
        set_frame(24'h010101, 24'h010201, 24'h010101, 12'd1, 13'd4);
        push_pixels(4, -1);
        push_pixels(1, -1);
        set_frame(24'h000000, 24'h000100, 24'h000000, 12'd0, 13'd0);
        push_pixels(2, -1);
        push_flushes(2);

        // random part
        while (words_in < 1200)
        begin
            km = $urandom_range(0, 2);
            if (!big_done && words_in > 600)
            begin
                set_frame(rand_krow(km), rand_krow(km), rand_krow(km), 12'hfff, 13'h1fff);
                push_pixels(300, -1);
                big_done = 1;
                continue;
            end
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            if ($urandom_range(0, 9) == 0) h = 8192 - $urandom_range(1, 4096);
            set_frame(rand_krow(km), rand_krow(km), rand_krow(km), 12'(w), 13'(h));
            w = (w == 0) ? 1 : w;
            h = (h == 0) ? 1 : h;
            repeat ($urandom_range(1, 3))
            begin
                if (h <= 6 && $urandom_range(0, 4) != 0)
                begin
                    push_pixels(w * h, -1);
                    push_flushes(w + $urandom_range(0, 2));
                end
                else
                begin
                    push_flushes($urandom_range(0, 1));
                    push_pixels($urandom_range(1, 3 * w), -1);
                    push_flushes($urandom_range(0, 3));
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    while (pending.size() != 0 || in_valid) @(posedge clk);
                    hold = 1;
                    while (expected_pix.size() != 0) @(posedge clk);
                    hold = 0;
                end
            end
        end

        wait_drained();
        $display("%0d words sent, %0d results checked (%0d via flush), %0d frames completed",
                 words_in, results_seen, flush_results, frames_done);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/ic3_pkg.sv
sv/ic3_ram.sv
sv/image_convolution_3x3.sv
tb/tb.sv
